@@ hw/rtl/pllap_pkg.sv @@
// ============================================================================
// pllap_pkg - shared types and constants for the polyline look-ahead block
// Opcodes, result kinds, iterative unit command type and fixed-point helpers.
// ============================================================================
`default_nettype none

package pllap_pkg;

    localparam logic [1:0] OP_APPEND   = 2'd0;
    localparam logic [1:0] OP_CLEAR    = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] CASE_EMPTY  = 2'd0;
    localparam logic [1:0] CASE_SINGLE = 2'd1;
    localparam logic [1:0] CASE_FULL   = 2'd2;

    localparam logic [30:0] LOOK_AHEAD_RESET = 31'd3276800;

    // Iteration counts of the shared unit
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] FRAC_STEPS = 7'd30;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    typedef enum logic [1:0] {
        MODE_DIV  = 2'd0,
        MODE_FRAC = 2'd1,
        MODE_SQRT = 2'd2
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_cmd_t;

    function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // Magnitude shifted right by two, sign kept
    function automatic logic signed [31:0] coarse33(input logic signed [32:0] v);
        logic [32:0] mg;
        logic signed [31:0] m;
        mg = mag33(v);
        m  = $signed({1'b0, mg[32:2]});
        return v[32] ? -m : m;
    endfunction

    function automatic logic signed [65:0] add_off(input logic signed [31:0] base,
                                                   input logic neg,
                                                   input logic [63:0] q);
        logic signed [65:0] qs;
        qs = $signed({2'b00, q});
        return $signed({{34{base[31]}}, base}) + (neg ? -qs : qs);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (!v[65] && (|v[64:31])) begin
            return 32'sh7FFF_FFFF;
        end else if (v[65] && !(&v[64:31])) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pllap_iter.sv @@
// ============================================================================
// pllap_iter - shared iterative divide / fraction / square root unit
// One quotient or root bit per cycle; done pulses when the result is ready.
// ============================================================================
`default_nettype none

module pllap_iter import pllap_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire iter_cmd_t   cmd,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    output logic             done,
    output logic [63:0]      result
);

    logic [63:0] r_reg, r_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] bit_reg, bit_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        sqrt_reg, sqrt_next;
    logic        done_reg, done_next;
    logic [63:0] shifted;
    logic [63:0] trial;

    assign shifted = {r_reg[62:0], q_reg[63]};
    assign trial   = q_reg + bit_reg;

    always_comb begin
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            d_next    = op_b;
            bit_next  = 64'h4000_0000_0000_0000;
            sqrt_next = (cmd.mode == MODE_SQRT);
            case (cmd.mode)
                MODE_DIV: begin
                    r_next   = '0;
                    q_next   = op_a;
                    cnt_next = DIV_STEPS;
                end
                MODE_FRAC: begin
                    r_next   = op_a;
                    q_next   = '0;
                    cnt_next = FRAC_STEPS;
                end
                MODE_SQRT: begin
                    r_next   = op_a;
                    q_next   = '0;
                    cnt_next = SQRT_STEPS;
                end
                default: begin
                    r_next   = '0;
                    q_next   = '0;
                    cnt_next = '0;
                end
            endcase
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
            if (sqrt_reg) begin
                if (r_reg >= trial) begin
                    r_next = r_reg - trial;
                    q_next = (q_reg >> 1) + bit_reg;
                end else begin
                    q_next = q_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end else if (shifted >= d_reg) begin
                r_next = shifted - d_reg;
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        r_reg    <= r_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        bit_reg  <= bit_next;
        sqrt_reg <= sqrt_next;
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/polyline_lookahead_point_top.sv @@
// Sequence: append and clear are handled in the idle state; a query projects onto each
//   stored segment, running the 30-step fraction divide when the foot falls inside it,
//   then measures each segment walked with the square root and divides for the final move.
// Throughput: one transaction at a time; the shared divide/sqrt unit sets the pace.
// Reset: synchronous active-low aresetn empties the path, restores the default
//   look-ahead distance and drops any pending result.
// ============================================================================
// polyline_lookahead_point_top - look-ahead point on a stored polyline
// Stores path points, finds the nearest projection of a queried position and
// walks ahead along the path by the configured distance.
// ============================================================================
`default_nettype none

module polyline_lookahead_point_top import pllap_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: look_ahead_distance
    input  wire logic         cfg_wr_en,
    input  wire logic [30:0]  cfg_wr_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // coord_x [31:0], coord_y [63:32]
    input  wire logic [1:0]   s_tuser,   // opcode [1:0]
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // ahead_x, ahead_y, closest_x, closest_y,
                                         // next_index [133:128], zero pad
    output logic [1:0]        m_tuser    // path_case [1:0]
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int ST_W = 41;

    typedef enum logic [ST_W-1:0] {
        S_IDLE  = ST_W'(1) << 0,
        S_ONE_A = ST_W'(1) << 1,
        S_ONE_B = ST_W'(1) << 2,
        S_RD_A  = ST_W'(1) << 3,
        S_RD_B  = ST_W'(1) << 4,
        S_RD_C  = ST_W'(1) << 5,
        S_DIFF  = ST_W'(1) << 6,
        S_M1    = ST_W'(1) << 7,
        S_M2    = ST_W'(1) << 8,
        S_M3    = ST_W'(1) << 9,
        S_M4    = ST_W'(1) << 10,
        S_M5    = ST_W'(1) << 11,
        S_CHK   = ST_W'(1) << 12,
        S_TDIV  = ST_W'(1) << 13,
        S_SC1   = ST_W'(1) << 14,
        S_SC2   = ST_W'(1) << 15,
        S_SC3   = ST_W'(1) << 16,
        S_EDIF  = ST_W'(1) << 17,
        S_D1    = ST_W'(1) << 18,
        S_D2    = ST_W'(1) << 19,
        S_D3    = ST_W'(1) << 20,
        S_W0    = ST_W'(1) << 21,
        S_W1    = ST_W'(1) << 22,
        S_W2    = ST_W'(1) << 23,
        S_W3    = ST_W'(1) << 24,
        S_W4    = ST_W'(1) << 25,
        S_WL0   = ST_W'(1) << 26,
        S_WL1   = ST_W'(1) << 27,
        S_WL2   = ST_W'(1) << 28,
        S_LC    = ST_W'(1) << 29,
        S_LM1   = ST_W'(1) << 30,
        S_LM2   = ST_W'(1) << 31,
        S_LM3   = ST_W'(1) << 32,
        S_LSQ   = ST_W'(1) << 33,
        S_AL1   = ST_W'(1) << 34,
        S_AL2   = ST_W'(1) << 35,
        S_AL3   = ST_W'(1) << 36,
        S_AL4   = ST_W'(1) << 37,
        S_AL5   = ST_W'(1) << 38,
        S_AL6   = ST_W'(1) << 39,
        S_DONE  = ST_W'(1) << 40
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [30:0]    la_reg;
    logic signed [31:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [AW-1:0]  idx_reg, idx_next, nidx_reg, nidx_next;
    logic signed [31:0] p0x_reg, p0x_next, p0y_reg, p0y_next;
    logic signed [31:0] p1x_reg, p1x_next, p1y_reg, p1y_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [31:0] cdx_reg, cdx_next, cdy_reg, cdy_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [63:0] acc_reg, acc_next, num_reg, num_next, den_reg, den_next;
    logic [29:0]    t_reg, t_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic [63:0]    best_reg, best_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [34:0]    len_reg, len_next;
    logic signed [35:0] rem_reg, rem_next;
    logic signed [31:0] bx_reg, bx_next, by_reg, by_next;
    logic [30:0]    amt_reg, amt_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [1:0]     pcase_reg, pcase_next;
    logic signed [67:0] mul_reg;
    logic signed [33:0] mul_a, mul_b;

    logic           m_tvalid_reg;
    logic [135:0]   m_tdata_reg;
    logic [1:0]     m_tuser_reg;
    logic           out_load;

    logic [63:0]    mem [MAX_POINTS];
    logic [63:0]    rdata_reg;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic signed [31:0] rd_x, rd_y;

    iter_cmd_t      icmd;
    logic [63:0]    iter_a, iter_b, iter_q;
    logic           iter_done;

    logic [CW:0]    cnt_ext, idx_ext, nidx_ext;
    logic signed [63:0] dist_sum;
    logic signed [35:0] rem_c, walk_diff;
    logic           rem_pos;

    pllap_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (icmd),
        .op_a    (iter_a),
        .op_b    (iter_b),
        .done    (iter_done),
        .result  (iter_q)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign rd_x     = rdata_reg[31:0];
    assign rd_y     = rdata_reg[63:32];
    assign cnt_ext  = (CW+1)'(cnt_reg);
    assign idx_ext  = (CW+1)'(idx_reg);
    assign nidx_ext = (CW+1)'(nidx_reg);
    assign dist_sum = acc_reg + mul_reg[63:0];
    assign rem_c    = $signed({5'b0, la_reg}) - $signed({1'b0, len_reg});
    assign walk_diff = rem_reg - $signed({1'b0, len_reg});
    assign rem_pos  = !rem_reg[35] && (rem_reg != '0);
    assign wr_en    = s_tvalid && s_tready && (s_tuser == OP_APPEND)
                      && (cnt_reg < CW'(MAX_POINTS));

    // Path point store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[AW-1:0]] <= s_tdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Read address follows the sequencer
    always_comb begin
        case (state_reg)
            S_RD_A:  rd_addr = idx_reg;
            S_RD_B:  rd_addr = idx_reg + AW'(1);
            S_ONE_A: rd_addr = '0;
            S_W0:    rd_addr = nidx_reg;
            S_W3:    rd_addr = nidx_reg - AW'(1);
            S_WL0:   rd_addr = idx_reg + AW'(1);
            default: rd_addr = idx_reg;
        endcase
    end

    // Shared multiplier, product registered every cycle
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        idx_next   = idx_reg;
        nidx_next  = nidx_reg;
        p0x_next   = p0x_reg;
        p0y_next   = p0y_reg;
        p1x_next   = p1x_reg;
        p1y_next   = p1y_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        cdx_next   = cdx_reg;
        cdy_next   = cdy_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        acc_next   = acc_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        t_next     = t_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        best_next  = best_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        amt_next   = amt_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        pcase_next = pcase_reg;
        mul_a      = '0;
        mul_b      = '0;
        icmd.start = 1'b0;
        icmd.mode  = MODE_DIV;
        iter_a     = mul_reg[63:0];
        iter_b     = {29'b0, len_reg};
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        OP_APPEND: begin
                            if (cnt_reg < CW'(MAX_POINTS)) begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_CLEAR: begin
                            cnt_next = '0;
                        end
                        OP_QUERY: begin
                            qx_next   = s_tdata[31:0];
                            qy_next   = s_tdata[63:32];
                            nidx_next = '0;
                            idx_next  = '0;
                            best_next = '1;
                            if (cnt_reg == '0) begin
                                ax_next    = s_tdata[31:0];
                                ay_next    = s_tdata[63:32];
                                cx_next    = s_tdata[31:0];
                                cy_next    = s_tdata[63:32];
                                pcase_next = CASE_EMPTY;
                                state_next = S_DONE;
                            end else if (cnt_reg == CW'(1)) begin
                                pcase_next = CASE_SINGLE;
                                state_next = S_ONE_A;
                            end else begin
                                pcase_next = CASE_FULL;
                                nidx_next  = AW'(1);
                                state_next = S_RD_A;
                            end
                        end
                        default: begin
                            // unknown opcode: drop the transaction
                        end
                    endcase
                end
            end
            S_ONE_A: state_next = S_ONE_B;
            S_ONE_B: begin
                ax_next    = rd_x;
                ay_next    = rd_y;
                cx_next    = rd_x;
                cy_next    = rd_y;
                state_next = S_DONE;
            end
            // ---- projection onto segment idx .. idx+1
            S_RD_A: state_next = S_RD_B;
            S_RD_B: begin
                p0x_next   = rd_x;
                p0y_next   = rd_y;
                state_next = S_RD_C;
            end
            S_RD_C: begin
                p1x_next   = rd_x;
                p1y_next   = rd_y;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                dx_next    = sub33(p1x_reg, p0x_reg);
                dy_next    = sub33(p1y_reg, p0y_reg);
                cdx_next   = coarse33(sub33(p1x_reg, p0x_reg));
                cdy_next   = coarse33(sub33(p1y_reg, p0y_reg));
                vx_next    = coarse33(sub33(qx_reg, p0x_reg));
                vy_next    = coarse33(sub33(qy_reg, p0y_reg));
                state_next = S_M1;
            end
            S_M1: begin
                mul_a      = 34'(cdx_reg);
                mul_b      = 34'(vx_reg);
                state_next = S_M2;
            end
            S_M2: begin
                mul_a      = 34'(cdy_reg);
                mul_b      = 34'(vy_reg);
                acc_next   = mul_reg[63:0];
                state_next = S_M3;
            end
            S_M3: begin
                num_next   = dist_sum;
                mul_a      = 34'(cdx_reg);
                mul_b      = 34'(cdx_reg);
                state_next = S_M4;
            end
            S_M4: begin
                mul_a      = 34'(cdy_reg);
                mul_b      = 34'(cdy_reg);
                acc_next   = mul_reg[63:0];
                state_next = S_M5;
            end
            S_M5: begin
                den_next   = dist_sum;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (den_reg == '0 || num_reg[63] || num_reg == '0) begin
                    px_next    = p0x_reg;
                    py_next    = p0y_reg;
                    state_next = S_EDIF;
                end else if (num_reg >= den_reg) begin
                    px_next    = p1x_reg;
                    py_next    = p1y_reg;
                    state_next = S_EDIF;
                end else begin
                    icmd.start = 1'b1;
                    icmd.mode  = MODE_FRAC;
                    iter_a     = num_reg;
                    iter_b     = den_reg;
                    state_next = S_TDIV;
                end
            end
            S_TDIV: begin
                if (iter_done) begin
                    t_next     = iter_q[29:0];
                    state_next = S_SC1;
                end
            end
            S_SC1: begin
                mul_a      = $signed({1'b0, mag33(dx_reg)});
                mul_b      = $signed({4'b0, t_reg});
                state_next = S_SC2;
            end
            S_SC2: begin
                mul_a      = $signed({1'b0, mag33(dy_reg)});
                mul_b      = $signed({4'b0, t_reg});
                px_next    = sat32(add_off(p0x_reg, dx_reg[32], {31'b0, mul_reg[62:30]}));
                state_next = S_SC3;
            end
            S_SC3: begin
                py_next    = sat32(add_off(p0y_reg, dy_reg[32], {31'b0, mul_reg[62:30]}));
                state_next = S_EDIF;
            end
            S_EDIF: begin
                vx_next    = coarse33(sub33(px_reg, qx_reg));
                vy_next    = coarse33(sub33(py_reg, qy_reg));
                state_next = S_D1;
            end
            S_D1: begin
                mul_a      = 34'(vx_reg);
                mul_b      = 34'(vx_reg);
                state_next = S_D2;
            end
            S_D2: begin
                mul_a      = 34'(vy_reg);
                mul_b      = 34'(vy_reg);
                acc_next   = mul_reg[63:0];
                state_next = S_D3;
            end
            S_D3: begin
                // keep the first strictly nearer projection
                if (dist_sum < best_reg) begin
                    best_next = dist_sum;
                    cx_next   = px_reg;
                    cy_next   = py_reg;
                    nidx_next = idx_reg + AW'(1);
                end
                if (idx_ext + (CW+1)'(2) < cnt_ext) begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_RD_A;
                end else begin
                    state_next = S_W0;
                end
            end
            // ---- walk ahead from the closest point
            S_W0: state_next = S_W1;
            S_W1: begin
                p1x_next   = rd_x;
                p1y_next   = rd_y;
                ux_next    = sub33(rd_x, cx_reg);
                uy_next    = sub33(rd_y, cy_reg);
                ret_next   = S_W2;
                state_next = S_LC;
            end
            S_W2: begin
                rem_next = rem_c;
                idx_next = nidx_reg;
                if (!rem_c[35] && rem_c != '0 && (nidx_ext + (CW+1)'(1) < cnt_ext)) begin
                    p0x_next   = p1x_reg;
                    p0y_next   = p1y_reg;
                    state_next = S_WL0;
                end else begin
                    state_next = S_W3;
                end
            end
            S_W3: state_next = S_W4;
            S_W4: begin
                ux_next = sub33(p1x_reg, rd_x);
                uy_next = sub33(p1y_reg, rd_y);
                if (rem_pos) begin
                    bx_next  = p1x_reg;
                    by_next  = p1y_reg;
                    amt_next = rem_reg[30:0];
                end else begin
                    bx_next  = cx_reg;
                    by_next  = cy_reg;
                    amt_next = la_reg;
                end
                ret_next   = S_AL1;
                state_next = S_LC;
            end
            S_WL0: begin
                if (idx_ext + (CW+1)'(1) < cnt_ext) begin
                    state_next = S_WL1;
                end else begin
                    // reached the last point: stay on it
                    bx_next    = p0x_reg;
                    by_next    = p0y_reg;
                    len_next   = '0;
                    state_next = S_AL1;
                end
            end
            S_WL1: begin
                p1x_next   = rd_x;
                p1y_next   = rd_y;
                ux_next    = sub33(rd_x, p0x_reg);
                uy_next    = sub33(rd_y, p0y_reg);
                ret_next   = S_WL2;
                state_next = S_LC;
            end
            S_WL2: begin
                if (!walk_diff[35] && walk_diff != '0) begin
                    rem_next   = walk_diff;
                    idx_next   = idx_reg + AW'(1);
                    p0x_next   = p1x_reg;
                    p0y_next   = p1y_reg;
                    state_next = S_WL0;
                end else begin
                    bx_next    = p0x_reg;
                    by_next    = p0y_reg;
                    amt_next   = rem_reg[30:0];
                    state_next = S_AL1;
                end
            end
            // ---- vector length of (ux, uy), returns to ret_reg
            S_LC: begin
                vx_next    = coarse33(ux_reg);
                vy_next    = coarse33(uy_reg);
                state_next = S_LM1;
            end
            S_LM1: begin
                mul_a      = 34'(vx_reg);
                mul_b      = 34'(vx_reg);
                state_next = S_LM2;
            end
            S_LM2: begin
                mul_a      = 34'(vy_reg);
                mul_b      = 34'(vy_reg);
                acc_next   = mul_reg[63:0];
                state_next = S_LM3;
            end
            S_LM3: begin
                icmd.start = 1'b1;
                icmd.mode  = MODE_SQRT;
                iter_a     = dist_sum;
                state_next = S_LSQ;
            end
            S_LSQ: begin
                if (iter_done) begin
                    len_next   = {iter_q[32:0], 2'b00};
                    state_next = ret_reg;
                end
            end
            // ---- move amt_reg along (ux, uy) from the base point
            S_AL1: begin
                if (len_reg == '0 || amt_reg == '0) begin
                    ax_next    = bx_reg;
                    ay_next    = by_reg;
                    state_next = S_DONE;
                end else begin
                    mul_a      = $signed({1'b0, mag33(ux_reg)});
                    mul_b      = $signed({3'b0, amt_reg});
                    state_next = S_AL2;
                end
            end
            S_AL2: begin
                icmd.start = 1'b1;
                icmd.mode  = MODE_DIV;
                state_next = S_AL3;
            end
            S_AL3: begin
                if (iter_done) begin
                    ax_next    = sat32(add_off(bx_reg, ux_reg[32], iter_q));
                    state_next = S_AL4;
                end
            end
            S_AL4: begin
                mul_a      = $signed({1'b0, mag33(uy_reg)});
                mul_b      = $signed({3'b0, amt_reg});
                state_next = S_AL5;
            end
            S_AL5: begin
                icmd.start = 1'b1;
                icmd.mode  = MODE_DIV;
                state_next = S_AL6;
            end
            S_AL6: begin
                if (iter_done) begin
                    ay_next    = sat32(add_off(by_reg, uy_reg[32], iter_q));
                    state_next = S_DONE;
                end
            end
            // ---- hand the result to the output register
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        idx_reg   <= idx_next;
        nidx_reg  <= nidx_next;
        p0x_reg   <= p0x_next;
        p0y_reg   <= p0y_next;
        p1x_reg   <= p1x_next;
        p1y_reg   <= p1y_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        cdx_reg   <= cdx_next;
        cdy_reg   <= cdy_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        acc_reg   <= acc_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        t_reg     <= t_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        best_reg  <= best_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ux_reg    <= ux_next;
        uy_reg    <= uy_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        amt_reg   <= amt_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        pcase_reg <= pcase_next;
    end

    // Look-ahead distance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            la_reg <= LOOK_AHEAD_RESET;
        end else if (cfg_wr_en) begin
            la_reg <= cfg_wr_data;
        end
    end

    // Output register: hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= {2'b00, 6'(nidx_reg), cy_reg, cx_reg, ay_reg, ax_reg};
            m_tuser_reg <= pcase_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_QUERY) |=> (state_reg != S_IDLE))
        else $error("query transaction did not start the sequencer");

    a_iter_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_done |-> (state_reg == S_TDIV || state_reg == S_LSQ ||
                       state_reg == S_AL3 || state_reg == S_AL6))
        else $error("shared unit finished outside a wait state");

    a_full_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && pcase_reg == CASE_FULL) |->
            (nidx_reg != '0 && (CW+1)'(nidx_reg) < cnt_ext))
        else $error("next index outside the stored path");
`endif

endmodule

`default_nettype wire
